/* src/rcbe_pkg.sv */
// ============================================================================
// rcbe_pkg: shared definitions for the RGBA canvas blend engine
// Store geometry, command and blend codes, channel words and the control
// word passed from the sequencer to the channel blend unit.
// ============================================================================
package rcbe_pkg;

    // Store geometry.
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Widths of pixels, register fields and clipped coordinates.
    localparam int PIX_W  = 32;
    localparam int CHAN_W = 8;
    localparam int REG_W  = 7;
    localparam int DIM_W  = 9;
    localparam int CFG_IDX_W = 2;

    // Register reset values.
    localparam logic [REG_W-1:0] CANVAS_RESET = 7'd64;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_RECT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_FILL  = 2'd3
    } cmd_op_t;

    typedef enum logic [1:0] {
        BLEND_REPLACE = 2'd0,
        BLEND_ALPHA   = 2'd1,
        BLEND_ADD     = 2'd2,
        BLEND_AVG     = 2'd3
    } blend_mode_t;

    // Command word.
    typedef struct packed {
        cmd_op_t     command;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [7:0]  rect_w;
        logic [7:0]  rect_h;
        logic [31:0] color;
        blend_mode_t blend_mode;
    } cmd_t;

    // Response word.
    typedef struct packed {
        logic [31:0] pixel_value;
        logic        in_range;
    } rsp_t;

    // Control from the sequencer to the channel blend unit.
    typedef struct packed {
        blend_mode_t mode;
        logic [1:0]  chan;
        logic        load_prod;
    } blend_ctrl_t;

endpackage

/* src/rcbe_store.sv */
// ============================================================================
// rcbe_store: pixel frame store
// Single write port and one registered read port with read enable.
// ============================================================================
module rcbe_store
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [rcbe_pkg::ADDR_W-1:0]            waddr,
    input  logic [rcbe_pkg::PIX_W-1:0]             wdata,
    input  logic                                   re,
    input  logic [rcbe_pkg::ADDR_W-1:0]            raddr,
    output logic [rcbe_pkg::PIX_W-1:0]             rdata
);

    logic [rcbe_pkg::PIX_W-1:0] mem [rcbe_pkg::STORE_DEPTH];
    logic [rcbe_pkg::PIX_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while the enable is low.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/rcbe_blend_unit.sv */
// ============================================================================
// rcbe_blend_unit: shared per-channel blend arithmetic
// Works on one 8-bit channel at a time. The alpha mode takes two steps: the
// product sum is registered, then divided by 255 through a reciprocal add.
// ============================================================================
module rcbe_blend_unit
(
    input  logic                              clk,
    input  rcbe_pkg::blend_ctrl_t             ctrl,
    input  logic [rcbe_pkg::PIX_W-1:0]        dst,
    input  logic [rcbe_pkg::PIX_W-1:0]        src,
    output logic [rcbe_pkg::CHAN_W-1:0]       res
);

    logic [7:0]  d;
    logic [7:0]  s;
    logic [7:0]  sa;
    logic [15:0] prod_next;
    logic [15:0] prod_reg;
    logic [16:0] div_sum;
    logic [8:0]  quot;
    logic [8:0]  pair_sum;
    logic [9:0]  alpha_sum;

    // Channel select; channel zero is alpha in the low byte.
    assign d  = dst[ctrl.chan * rcbe_pkg::CHAN_W +: rcbe_pkg::CHAN_W];
    assign s  = src[ctrl.chan * rcbe_pkg::CHAN_W +: rcbe_pkg::CHAN_W];
    assign sa = src[7:0];

    // Product step: d*s for alpha, weighted sum for the color channels.
    always_comb
    begin
        if (ctrl.chan == 2'd0)
        begin
            prod_next = {8'd0, d} * {8'd0, s};
        end
        else
        begin
            prod_next = {8'd0, d} * {8'd0, 8'd255 - sa} + {8'd0, s} * {8'd0, sa};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    // Exact division by 255 for any value below 65535, so for every product sum.
    assign div_sum   = {1'b0, prod_reg} + 17'd1 + {9'd0, prod_reg[15:8]};
    assign quot      = div_sum[16:8];
    assign pair_sum  = {1'b0, d} + {1'b0, s};
    assign alpha_sum = {2'b00, d} + {2'b00, s} - {1'b0, quot};

    // Result select by blend mode.
    always_comb
    begin
        case (ctrl.mode)
            rcbe_pkg::BLEND_REPLACE:
            begin
                res = s;
            end
            rcbe_pkg::BLEND_ALPHA:
            begin
                res = (ctrl.chan == 2'd0) ? alpha_sum[7:0] : quot[7:0];
            end
            rcbe_pkg::BLEND_ADD:
            begin
                res = pair_sum[8] ? 8'd255 : pair_sum[7:0];
            end
            default:
            begin
                res = pair_sum[8:1];
            end
        endcase
    end

endmodule

/* src/rgba_canvas_blend_engine_unit.sv */
// ============================================================================
// rgba_canvas_blend_engine_unit: RGBA canvas with blended draws and fills
// Sequencer over a frame store and one shared channel blend unit.
// ============================================================================
//
//  Channel | Signals                          | Word
//  --------+----------------------------------+------------------------------
//  command | cmd_valid, cmd_ready, cmd        | rcbe_pkg::cmd_t
//  result  | rsp_valid, rsp_ready, rsp        | rcbe_pkg::rsp_t
//  config  | cfg_valid, cfg_ready, cfg_index, | 7-bit register data
//          | cfg_data                         |
//
//  Each drawn pixel passes through address, store read, four channels of
//  two steps each through the shared blend unit, and the write back. A read
//  passes through address, store read and result; a fill writes one pixel
//  a cycle, width times height in all. The store has a single write port.
//  After reset a clearing pass writes zero to all 4096 entries, one a cycle,
//  before the first command word is taken; configuration writes are always
//  taken. A stalled result holds the sequencer in its final state.
// ============================================================================
module rgba_canvas_blend_engine_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  rcbe_pkg::cmd_t                        cmd,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output rcbe_pkg::rsp_t                        rsp,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rcbe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rcbe_pkg::REG_W-1:0]            cfg_data
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_ADDR   = 9'b000000100,
        S_READ   = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_WRITE  = 9'b001000000,
        S_FILL   = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    localparam logic [rcbe_pkg::ADDR_W-1:0] LAST_ADDR =
        rcbe_pkg::ADDR_W'(rcbe_pkg::STORE_DEPTH - 1);
    localparam logic [rcbe_pkg::DIM_W-1:0] MAX_W_DIM =
        rcbe_pkg::DIM_W'(rcbe_pkg::MAX_WIDTH);
    localparam logic [rcbe_pkg::DIM_W-1:0] MAX_H_DIM =
        rcbe_pkg::DIM_W'(rcbe_pkg::MAX_HEIGHT);

    state_t state_reg, state_next;

    logic [rcbe_pkg::REG_W-1:0]  width_reg, height_reg;
    logic [rcbe_pkg::DIM_W-1:0]  cw, ch;
    logic [rcbe_pkg::DIM_W-1:0]  width_ext, height_ext;

    // Per-command registers.
    rcbe_pkg::cmd_op_t           op_reg;
    rcbe_pkg::blend_mode_t       mode_reg;
    logic [rcbe_pkg::PIX_W-1:0]  color_reg;
    logic                        flag_reg;
    logic [7:0]                  x0_reg, cur_x_reg, cur_y_reg;
    logic [rcbe_pkg::DIM_W-1:0]  x_end_reg, y_end_reg;
    logic [rcbe_pkg::ADDR_W-1:0] addr_reg;
    logic [rcbe_pkg::ADDR_W-1:0] sweep_reg;
    logic [rcbe_pkg::ADDR_W-1:0] fill_last_reg;
    logic [1:0]                  chan_reg;
    logic [rcbe_pkg::PIX_W-1:0]  new_pix_reg;

    logic                        rsp_valid_reg;
    rcbe_pkg::rsp_t              rsp_reg;

    // Datapath wires.
    logic                        accept;
    logic                        in_canvas;
    logic [rcbe_pkg::DIM_W-1:0]  pos_x_ext, pos_y_ext;
    logic [rcbe_pkg::DIM_W-1:0]  rx_end, ry_end;
    logic [2*rcbe_pkg::DIM_W-1:0] fill_count, fill_last_full;
    logic [16:0]                 addr_full;
    logic [rcbe_pkg::DIM_W-1:0]  next_x, next_y;
    logic                        rsp_free;

    logic                        st_we, st_re;
    logic [rcbe_pkg::ADDR_W-1:0] st_waddr;
    logic [rcbe_pkg::PIX_W-1:0]  st_wdata, st_rdata;

    rcbe_pkg::blend_ctrl_t       bctrl;
    logic [rcbe_pkg::CHAN_W-1:0] bres;

    // Active canvas size, saturated at the store geometry.
    assign width_ext  = {2'b00, width_reg};
    assign height_ext = {2'b00, height_reg};
    assign cw = (width_ext  > MAX_W_DIM) ? MAX_W_DIM : width_ext;
    assign ch = (height_ext > MAX_H_DIM) ? MAX_H_DIM : height_ext;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rcbe_pkg::CANVAS_RESET;
            height_reg <= rcbe_pkg::CANVAS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rcbe_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                rcbe_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Command decode at acceptance.
    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign pos_x_ext = {1'b0, cmd.pos_x};
    assign pos_y_ext = {1'b0, cmd.pos_y};
    assign in_canvas = (pos_x_ext < cw) && (pos_y_ext < ch);

    // Rectangle ends, computed at nine bits and clipped to the canvas.
    always_comb
    begin
        rx_end = pos_x_ext + {1'b0, cmd.rect_w};
        ry_end = pos_y_ext + {1'b0, cmd.rect_h};
        if (cmd.command == rcbe_pkg::CMD_PIXEL)
        begin
            rx_end = pos_x_ext + 9'd1;
            ry_end = pos_y_ext + 9'd1;
        end
        if (rx_end > cw)
        begin
            rx_end = cw;
        end
        if (ry_end > ch)
        begin
            ry_end = ch;
        end
    end

    assign fill_count     = {9'd0, cw} * {9'd0, ch};
    assign fill_last_full = fill_count - 18'd1;

    // Store address of the current pixel.
    assign addr_full = {9'd0, cur_y_reg} * {8'd0, cw} + {9'd0, cur_x_reg};
    assign next_x    = {1'b0, cur_x_reg} + 9'd1;
    assign next_y    = {1'b0, cur_y_reg} + 9'd1;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.command) inside
                        rcbe_pkg::CMD_PIXEL, rcbe_pkg::CMD_READ:
                        begin
                            state_next = in_canvas ? S_ADDR : S_FINISH;
                        end
                        rcbe_pkg::CMD_RECT:
                        begin
                            state_next = (in_canvas && cmd.rect_w != 8'd0 &&
                                          cmd.rect_h != 8'd0) ? S_ADDR : S_FINISH;
                        end
                        default:
                        begin
                            state_next = (fill_count != 18'd0) ? S_FILL : S_FINISH;
                        end
                    endcase
                end
            end
            S_ADDR:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = (op_reg == rcbe_pkg::CMD_READ) ? S_FINISH : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = (chan_reg == 2'd3) ? S_WRITE : S_MUL;
            end
            S_WRITE:
            begin
                if (next_x < x_end_reg || next_y < y_end_reg)
                begin
                    state_next = S_ADDR;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FILL:
            begin
                if (sweep_reg == fill_last_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_CLEAR) || (state_reg == S_FILL))
            begin
                sweep_reg <= sweep_reg + rcbe_pkg::ADDR_W'(1);
            end
            else
            begin
                sweep_reg <= '0;
            end
        end
    end

    // Command fields and the pixel walk.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= cmd.command;
            mode_reg      <= cmd.blend_mode;
            color_reg     <= cmd.color;
            x0_reg        <= cmd.pos_x;
            cur_x_reg     <= cmd.pos_x;
            cur_y_reg     <= cmd.pos_y;
            x_end_reg     <= rx_end;
            y_end_reg     <= ry_end;
            fill_last_reg <= fill_last_full[rcbe_pkg::ADDR_W-1:0];
            if (cmd.command == rcbe_pkg::CMD_FILL)
            begin
                flag_reg <= (fill_count != 18'd0);
            end
            else
            begin
                flag_reg <= in_canvas;
            end
        end
        if (state_reg == S_ADDR)
        begin
            addr_reg <= addr_full[rcbe_pkg::ADDR_W-1:0];
        end
        if (state_reg == S_WRITE)
        begin
            if (next_x < x_end_reg)
            begin
                cur_x_reg <= next_x[7:0];
            end
            else
            begin
                cur_x_reg <= x0_reg;
                cur_y_reg <= next_y[7:0];
            end
        end
        if (state_reg == S_READ)
        begin
            chan_reg <= 2'd0;
        end
        else if (state_reg == S_DIV)
        begin
            chan_reg <= chan_reg + 2'd1;
            new_pix_reg[chan_reg * rcbe_pkg::CHAN_W +: rcbe_pkg::CHAN_W] <= bres;
        end
    end

    // Store port steering.
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = addr_reg;
        st_wdata = new_pix_reg;
        if (state_reg == S_CLEAR)
        begin
            st_we    = 1'b1;
            st_waddr = sweep_reg;
            st_wdata = '0;
        end
        else if (state_reg == S_FILL)
        begin
            st_we    = 1'b1;
            st_waddr = sweep_reg;
            st_wdata = color_reg;
        end
        else if (state_reg == S_WRITE)
        begin
            st_we = 1'b1;
        end
    end

    assign st_re = (state_reg == S_READ);

    rcbe_store u_store
    (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (addr_reg),
        .rdata (st_rdata)
    );

    // Shared channel blend unit.
    assign bctrl.mode      = mode_reg;
    assign bctrl.chan      = chan_reg;
    assign bctrl.load_prod = (state_reg == S_MUL);

    rcbe_blend_unit u_blend
    (
        .clk  (clk),
        .ctrl (bctrl),
        .dst  (st_rdata),
        .src  (color_reg),
        .res  (bres)
    );

    // Result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_FINISH) && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_FINISH) && rsp_free)
        begin
            rsp_reg.in_range <= flag_reg;
            if ((op_reg == rcbe_pkg::CMD_READ) && flag_reg)
            begin
                rsp_reg.pixel_value <= st_rdata;
            end
            else
            begin
                rsp_reg.pixel_value <= '0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* tb/canvas_checker.sv */
// ============================================================================
// canvas_checker: prediction and comparison for the RGBA canvas engine
// Watches the command, result and register channels, keeps its own copy of
// the frame store and canvas size, predicts one result word per accepted
// command and compares it field by field with the words the block returns.
// ============================================================================
module canvas_checker
    import rcbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_ready,
    input  cmd_t                 cmd,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  rsp_t                 rsp,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow of the frame store and the two size registers.
    logic [PIX_W-1:0] canvas_mem [STORE_DEPTH];
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;

    // Result words still owed by the block, oldest first.
    rsp_t pending_rsp [$];

    // One 8-bit channel of a blended draw.
    function automatic logic [7:0] mix_channel(logic [7:0] dst, logic [7:0] src,
                                               logic [7:0] src_alpha,
                                               blend_mode_t mode, bit alpha_lane);
        int unsigned d;
        int unsigned s;
        int unsigned a;
        int unsigned r;
        d = dst;
        s = src;
        a = src_alpha;
        case (mode)
            BLEND_ALPHA:
            begin
                // The alpha lane combines coverage, the color lanes do source-over.
                if (alpha_lane)
                    r = d + s - (d * s) / 255;
                else
                    r = (d * (255 - a) + s * a) / 255;
            end
            BLEND_ADD:
                r = (d + s > 255) ? 255 : d + s;
            default:
                r = (d + s) / 2;
        endcase
        return r[7:0];
    endfunction

    // New pixel value for a draw over an existing pixel.
    function automatic logic [PIX_W-1:0] blend_pixel(logic [PIX_W-1:0] dst,
                                                     logic [PIX_W-1:0] src,
                                                     blend_mode_t mode);
        logic [PIX_W-1:0] mixed;
        if (mode == BLEND_REPLACE)
            return src;
        for (int k = 0; k < 4; k++)
            mixed[8*k +: 8] = mix_channel(dst[8*k +: 8], src[8*k +: 8], src[7:0],
                                          mode, k == 0);
        return mixed;
    endfunction

    // Carries out one command on the shadow store and returns its result word.
    function automatic rsp_t apply_command(cmd_t word);
        int unsigned aw;
        int unsigned ah;
        int unsigned x;
        int unsigned y;
        int unsigned x_end;
        int unsigned y_end;
        bit          hit;
        rsp_t        res;
        aw = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        ah = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        x = word.pos_x;
        y = word.pos_y;
        hit = (x < aw) && (y < ah);
        res.pixel_value = '0;
        res.in_range = hit;
        case (word.command)
            CMD_PIXEL:
            begin
                if (hit)
                    canvas_mem[y*aw + x] = blend_pixel(canvas_mem[y*aw + x], word.color,
                                                       word.blend_mode);
            end
            CMD_RECT:
            begin
                // Ends are taken at full width, then clipped to the canvas.
                if (hit && word.rect_w != 0 && word.rect_h != 0)
                begin
                    x_end = x + word.rect_w;
                    y_end = y + word.rect_h;
                    if (x_end > aw)
                        x_end = aw;
                    if (y_end > ah)
                        y_end = ah;
                    for (int unsigned r = y; r < y_end; r++)
                        for (int unsigned q = x; q < x_end; q++)
                            canvas_mem[r*aw + q] = blend_pixel(canvas_mem[r*aw + q],
                                                               word.color,
                                                               word.blend_mode);
                end
            end
            CMD_READ:
            begin
                if (hit)
                    res.pixel_value = canvas_mem[y*aw + x];
            end
            default:
            begin
                // Fill ignores the blend mode and writes the linear prefix.
                res.in_range = (aw * ah != 0);
                for (int unsigned i = 0; i < aw * ah; i++)
                    canvas_mem[i] = word.color;
            end
        endcase
        return res;
    endfunction

    // Channel monitor: compare results, track registers, predict commands.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
                canvas_mem[i] = '0;
            width_reg = CANVAS_RESET;
            height_reg = CANVAS_RESET;
            pending_rsp.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result word with no command pending: pixel_value %08h in_range %0d",
                           rsp.pixel_value, rsp.in_range);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.pixel_value !== want.pixel_value)
                    begin
                        $error("pixel_value mismatch: expected %08h, actual %08h",
                               want.pixel_value, rsp.pixel_value);
                        fail_count = fail_count + 1;
                    end
                    if (rsp.in_range !== want.in_range)
                    begin
                        $error("in_range mismatch: expected %0d, actual %0d",
                               want.in_range, rsp.in_range);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg = cfg_data;
                    CFG_HEIGHT: height_reg = cfg_data;
                    default:    ;
                endcase
            end
            if (cmd_valid && cmd_ready)
                pending_rsp.push_back(apply_command(cmd));
        end
        outstanding = pending_rsp.size();
    end

endmodule

/* tb/testbench.sv */
// ============================================================================
// testbench: stimulus and verdict for the RGBA canvas blend engine
// Drives directed and random command words over several canvas sizes and
// handshake idling patterns; a separate checker predicts and compares.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rcbe_pkg::*;

    // Register indexes the block does not decode.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int PHASES         = 12;
    localparam int ITEMS_PER_PHASE = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_ready;
    cmd_t                 cmd = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data = '0;

    int fail_count;
    int outstanding;

    // Idling in percent of cycles, and the active canvas as last configured.
    int send_idle  = 0;
    int recv_stall = 0;
    int canvas_w   = 64;
    int canvas_h   = 64;

    // Canvas sizes per random phase, the extremes among them.
    int phase_w [PHASES] = '{8, 127, 1, 64, 0, 13, 5, 64, 37, 2, 100, 16};
    int phase_h [PHASES] = '{8, 100, 64, 1, 5, 0, 7, 64, 21, 2, 3, 127};

    rgba_canvas_blend_engine_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    canvas_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result side: stall at random at the current rate.
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Hard limit on the run time.
    initial
    begin
        #50_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Sends one command word; entered and left at a falling edge.
    task automatic push_cmd(input cmd_t word);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= word;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds the command side until every predicted word has come back.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // One register write; the caller lowers the valid after a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Resizes the canvas and pokes one undecoded index as well.
    task automatic set_canvas(input int w, input int h);
        write_reg(CFG_WIDTH, w[REG_W-1:0]);
        write_reg(CFG_HEIGHT, h[REG_W-1:0]);
        write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, REG_W'($urandom()));
        cfg_valid <= 1'b0;
        canvas_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        canvas_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    endtask

    function automatic cmd_t make_cmd(cmd_op_t op, int x, int y, int w, int h,
                                      logic [31:0] color, blend_mode_t mode);
        cmd_t word;
        word.command = op;
        word.pos_x = x[7:0];
        word.pos_y = y[7:0];
        word.rect_w = w[7:0];
        word.rect_h = h[7:0];
        word.color = color;
        word.blend_mode = mode;
        return word;
    endfunction

    // Mostly inside the canvas, sometimes anywhere in the 8-bit range.
    function automatic logic [7:0] pick_coord(int span);
        if (span == 0 || $urandom_range(99) < 12)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, span - 1));
    endfunction

    // A position in the last few columns or rows, for wide clipped rectangles.
    function automatic logic [7:0] near_edge(int span);
        if (span == 0)
            return 8'($urandom_range(0, 3));
        return 8'($urandom_range(span > 3 ? span - 3 : 0, span - 1));
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t word;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 30)
            word.command = CMD_PIXEL;
        else if (pick < 62)
            word.command = CMD_RECT;
        else if (pick < 97)
            word.command = CMD_READ;
        else
            word.command = CMD_FILL;
        word.pos_x = pick_coord(canvas_w);
        word.pos_y = pick_coord(canvas_h);
        word.rect_w = 8'($urandom_range(0, 5));
        word.rect_h = 8'($urandom_range(0, 5));
        // Large sizes only next to the edge, so the clipped area stays small.
        if ($urandom_range(9) == 0)
        begin
            word.rect_w = 8'($urandom_range(0, 255));
            word.pos_x = near_edge(canvas_w);
        end
        if ($urandom_range(9) == 0)
        begin
            word.rect_h = 8'($urandom_range(0, 255));
            word.pos_y = near_edge(canvas_h);
        end
        word.color = $urandom();
        case ($urandom_range(4))
            0:       word.color[7:0] = 8'h00;
            1:       word.color[7:0] = 8'hFF;
            default: ;
        endcase
        word.blend_mode = blend_mode_t'($urandom_range(0, 3));
        return word;
    endfunction

    // Main sequence: reset, directed words, then random phases.
    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_canvas(64, 64);

        // Cleared store, each blend mode on one pixel, then read back.
        push_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 32'h0, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 32'h80402010, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 32'hF0C03080, BLEND_ALPHA));
        push_cmd(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 32'hFFFFFFFF, BLEND_ADD));
        push_cmd(make_cmd(CMD_PIXEL, 0, 0, 0, 0, 32'h01234567, BLEND_AVG));
        push_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 32'h0, BLEND_REPLACE));
        // Out of bounds draw and read, and the last in-bounds pixel.
        push_cmd(make_cmd(CMD_PIXEL, 255, 255, 0, 0, 32'hDEADBEEF, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_READ, 255, 255, 0, 0, 32'h0, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_READ, 63, 63, 0, 0, 32'h0, BLEND_REPLACE));
        // Rectangles: empty sizes, clipped at the corner, origin outside.
        push_cmd(make_cmd(CMD_RECT, 1, 1, 0, 4, 32'hAAAAAAAA, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_RECT, 1, 1, 4, 0, 32'h55555555, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_RECT, 62, 62, 255, 255, 32'h12345678, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_READ, 63, 63, 0, 0, 32'h0, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_RECT, 64, 0, 4, 4, 32'hFFFFFFFF, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_RECT, 2, 2, 3, 3, 32'h336699FF, BLEND_ALPHA));
        push_cmd(make_cmd(CMD_RECT, 2, 2, 3, 3, 32'hFFFFFF00, BLEND_ALPHA));
        push_cmd(make_cmd(CMD_READ, 3, 3, 0, 0, 32'h0, BLEND_REPLACE));
        // Fill ignores the mode; a fill with zero clears.
        push_cmd(make_cmd(CMD_FILL, 200, 200, 0, 0, 32'hC0FFEE77, BLEND_ALPHA));
        push_cmd(make_cmd(CMD_READ, 10, 10, 0, 0, 32'h0, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_PIXEL, 10, 10, 0, 0, 32'h11223300, BLEND_ALPHA));
        push_cmd(make_cmd(CMD_READ, 10, 10, 0, 0, 32'h0, BLEND_REPLACE));
        push_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 32'h0, BLEND_ADD));
        push_cmd(make_cmd(CMD_READ, 63, 63, 0, 0, 32'h0, BLEND_REPLACE));
        wait_drained();

        // Random phases, each with its own canvas size and idling pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle = 0;
            recv_stall = 0;
            set_canvas(phase_w[p], phase_h[p]);
            case (p % 4)
                1:       send_idle = 88;
                2:       recv_stall = 88;
                3:
                begin
                    send_idle = 23;
                    recv_stall = 23;
                end
                default: ;
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                push_cmd(random_cmd());
                if ($urandom_range(49) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* sim.f */
src/rcbe_pkg.sv
src/rcbe_store.sv
src/rcbe_blend_unit.sv
src/rgba_canvas_blend_engine_unit.sv
tb/canvas_checker.sv
tb/testbench.sv
